// ===== hw/rtl/rdbw_pkg.sv =====
`default_nettype none
package rdbw_pkg;

  localparam logic [11:0] YEAR_BASE = 12'd2000;
  localparam logic [11:0] YEAR_LAST = 12'd2099;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [3:0]  MONTH_MARCH = 4'd3;
  localparam logic [4:0]  DAY_FIRST = 5'd1;
  localparam logic [4:0]  HOUR_LAST = 5'd23;
  localparam logic [4:0]  HOUR_NOON = 5'd12;
  localparam logic [5:0]  MINUTE_LAST = 6'd59;
  localparam logic [6:0]  YY_LAST = 7'd99;

  typedef struct packed {
    logic [11:0] year_full;
    logic [3:0]  month_num;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_24;
    logic [5:0]  minute_num;
  } in_t;

  typedef struct packed {
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [7:0] hour_byte;
    logic [6:0] minute_bcd;
    logic       range_error;
  } enc_t;

  // packed bcd of 0..99, tens by multiply with 205/2048
  function automatic logic [7:0] bcd7(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = {8'd0, v} * 15'd205;
    tens = p[14:11];
    ones = v - ({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  // floor(26*(m+1)/10) with january and february as months 13 and 14
  function automatic logic [5:0] month_term(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // 8 = 1 mod 7, so octal digits fold
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = {2'd0, x[2:0]} + {2'd0, x[5:3]} + {3'd0, x[7:6]};
    s2 = {1'b0, s1[2:0]} + {2'd0, s1[4:3]};
    r  = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
    return r[2:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rdbw_field_enc.sv =====
`default_nettype none
module rdbw_field_enc (
  input  var rdbw_pkg::in_t  din,
  output var rdbw_pkg::enc_t enc
);

  logic [11:0] yy_full;
  logic [4:0]  h12;
  logic        pm;
  logic [7:0]  hour_bcd;
  logic [7:0]  month_b;
  logic [7:0]  day_b;
  logic [7:0]  minute_b;

  assign yy_full = din.year_full - rdbw_pkg::YEAR_BASE;

  // hour 0 is 12 am, hour 12 is 12 pm
  assign pm  = din.hour_24 >= rdbw_pkg::HOUR_NOON;
  assign h12 = (din.hour_24 == 5'd0) ? rdbw_pkg::HOUR_NOON :
               (din.hour_24 > rdbw_pkg::HOUR_NOON) ? (din.hour_24 - rdbw_pkg::HOUR_NOON) :
               din.hour_24;

  assign hour_bcd = rdbw_pkg::bcd7({2'd0, h12});
  assign month_b  = rdbw_pkg::bcd7({3'd0, din.month_num});
  assign day_b    = rdbw_pkg::bcd7({2'd0, din.day_of_month});
  assign minute_b = rdbw_pkg::bcd7({1'b0, din.minute_num});

  always_comb begin
    enc.year_bcd    = rdbw_pkg::bcd7(yy_full[6:0]);
    enc.month_bcd   = month_b[4:0];
    enc.day_bcd     = day_b[5:0];
    enc.hour_byte   = {1'b1, 1'b0, pm, hour_bcd[4:0]};
    enc.minute_bcd  = minute_b[6:0];
    enc.range_error = (din.year_full < rdbw_pkg::YEAR_BASE) ||
                      (din.year_full > rdbw_pkg::YEAR_LAST) ||
                      (din.month_num < rdbw_pkg::MONTH_FIRST) ||
                      (din.month_num > rdbw_pkg::MONTH_LAST) ||
                      (din.day_of_month < rdbw_pkg::DAY_FIRST) ||
                      (din.hour_24 > rdbw_pkg::HOUR_LAST) ||
                      (din.minute_num > rdbw_pkg::MINUTE_LAST);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rdbw_weekday.sv =====
`default_nettype none
module rdbw_weekday (
  input  var rdbw_pkg::in_t din,
  output logic [2:0]        weekday_code
);

  logic [11:0] yy_full;
  logic [6:0]  yy;
  logic        jan_feb;
  logic [6:0]  k;
  logic        c_term;
  logic [7:0]  sum;
  logic [2:0]  h;
  logic [3:0]  t;

  assign yy_full = din.year_full - rdbw_pkg::YEAR_BASE;
  assign yy      = yy_full[6:0];
  assign jan_feb = din.month_num < rdbw_pkg::MONTH_MARCH;

  // century 20: c/4 + 5c = 105 = 0 mod 7; century 19 (jan/feb 2000): 99 = 1 mod 7
  always_comb begin
    if (jan_feb && (yy == 7'd0)) begin
      k      = rdbw_pkg::YY_LAST;
      c_term = 1'b1;
    end else if (jan_feb) begin
      k      = yy - 7'd1;
      c_term = 1'b0;
    end else begin
      k      = yy;
      c_term = 1'b0;
    end
  end

  assign sum = {3'd0, din.day_of_month} + {2'd0, rdbw_pkg::month_term(din.month_num)} +
               {1'b0, k} + {3'd0, k[6:2]} + {7'd0, c_term};

  assign h = rdbw_pkg::mod7(sum);

  // h: 0 saturday .. 6 friday, remapped to 1 monday .. 7 sunday
  assign t            = {1'b0, h} + 4'd5;
  assign weekday_code = ((t >= 4'd7) ? (t[2:0] - 3'd7) : t[2:0]) + 3'd1;

endmodule
`default_nettype wire

// ===== hw/rtl/rtc_date_to_bcd_weekday_top.sv =====
// result: a beat taken into the input register shows on the result ports with
// done high once the result register has loaded it, for exactly one cycle
// throughput: one beat per cycle, busy stays low; the receiver cannot stall
// reset: synchronous active-high rst clears the input and result valid flags
`default_nettype none
module rtc_date_to_bcd_weekday_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] year_full,
  input  logic [3:0]  month_num,
  input  logic [4:0]  day_of_month,
  input  logic [4:0]  hour_24,
  input  logic [5:0]  minute_num,
  output logic        done,
  output logic [7:0]  year_bcd,
  output logic [4:0]  month_bcd,
  output logic [5:0]  day_bcd,
  output logic [7:0]  hour_byte,
  output logic [6:0]  minute_bcd,
  output logic [2:0]  weekday_code,
  output logic        range_error
);

  rdbw_pkg::in_t  in_reg;
  logic           in_vld;
  rdbw_pkg::enc_t enc;
  logic [2:0]     wday;
  rdbw_pkg::enc_t res;
  logic [2:0]     res_wday;
  rdbw_pkg::enc_t res_next;
  logic [2:0]     res_wday_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      in_vld <= start;
      done   <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_reg.year_full    <= year_full;
      in_reg.month_num    <= month_num;
      in_reg.day_of_month <= day_of_month;
      in_reg.hour_24      <= hour_24;
      in_reg.minute_num   <= minute_num;
    end
  end

  rdbw_field_enc u_enc (
    .din (in_reg),
    .enc (enc)
  );

  rdbw_weekday u_wday (
    .din          (in_reg),
    .weekday_code (wday)
  );

  // out-of-range beat: all fields zero, only the error flag set
  always_comb begin
    res_next      = enc;
    res_wday_next = wday;
    if (enc.range_error) begin
      res_next             = '0;
      res_next.range_error = 1'b1;
      res_wday_next        = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      res      <= res_next;
      res_wday <= res_wday_next;
    end
  end

  assign year_bcd     = res.year_bcd;
  assign month_bcd    = res.month_bcd;
  assign day_bcd      = res.day_bcd;
  assign hour_byte    = res.hour_byte;
  assign minute_bcd   = res.minute_bcd;
  assign range_error  = res.range_error;
  assign weekday_code = res_wday;

endmodule
`default_nettype wire
